@@ rtl/core/psdf_pkg.sv @@
// Package for the per-sender duplicate filter: result codes, command codes and
// the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package psdf_pkg;

   localparam logic [1:0] STATUS_ACK  = 2'd0;
   localparam logic [1:0] STATUS_DROP = 2'd1;
   localparam logic [1:0] STATUS_TICK = 2'd2;

   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [7:0] IDLE_LIMIT_RESET = 8'd30;

   typedef struct packed {
      logic capture;
      logic rd_s;
      logic rd_cnt;
      logic s_inc;
      logic load_found;
      logic load_new;
      logic calc_base;
      logic h_rd;
      logic h_inc;
      logic set_seen;
      logic update;
      logic ack_set;
      logic a_rd;
      logic load_ack;
      logic load_drop;
      logic evict;
      logic mv_write;
      logic mp_write;
      logic load_tick;
   } psdf_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic s_at_end;
      logic key_match;
      logic full;
      logic h_at_end;
      logic h_match;
      logic out_free;
      logic idle_hit;
      logic i_is_last;
      logic rem_last;
   } psdf_stat_type;

endpackage

@@ rtl/core/psdf_req_if.sv @@
// Request channel interface: valid/ready plus one packet or tick item.
// No dependencies.
`timescale 1ns / 1ps

interface psdf_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] src_addr;
   logic [15:0] src_port;
   logic [31:0] msg_index;

   modport source (output valid, command, src_addr, src_port, msg_index, input ready);
   modport sink   (input valid, command, src_addr, src_port, msg_index, output ready);
endinterface

@@ rtl/core/psdf_rsp_if.sv @@
// Response channel interface: valid/ready plus one result item.
// No dependencies.
`timescale 1ns / 1ps

interface psdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        is_new;
   logic [31:0] ack_index;
   logic [8:0]  evicted;
   logic        last;

   modport source (output valid, status, is_new, ack_index, evicted, last, input ready);
   modport sink   (input valid, status, is_new, ack_index, evicted, last, output ready);
endinterface

@@ rtl/core/psdf_ctrl.sv @@
// Sequencer for the duplicate filter: search, history scan, update, ack and
// aging sweep. Depends on psdf_pkg.
`timescale 1ns / 1ps

module psdf_ctrl import psdf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output psdf_cmd_type  cmd,
   input  psdf_stat_type stat
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_P_RD  = 5'd1;
   localparam logic [4:0] ST_P_CMP = 5'd2;
   localparam logic [4:0] ST_P_NEW = 5'd3;
   localparam logic [4:0] ST_P_NLD = 5'd4;
   localparam logic [4:0] ST_DROP  = 5'd5;
   localparam logic [4:0] ST_BASE  = 5'd6;
   localparam logic [4:0] ST_H_RD  = 5'd7;
   localparam logic [4:0] ST_H_CMP = 5'd8;
   localparam logic [4:0] ST_H_UPD = 5'd9;
   localparam logic [4:0] ST_A_SET = 5'd10;
   localparam logic [4:0] ST_A_RD  = 5'd11;
   localparam logic [4:0] ST_A_LD  = 5'd12;
   localparam logic [4:0] ST_T_RD  = 5'd13;
   localparam logic [4:0] ST_T_CK  = 5'd14;
   localparam logic [4:0] ST_T_MRD = 5'd15;
   localparam logic [4:0] ST_T_MV  = 5'd16;
   localparam logic [4:0] ST_T_MP  = 5'd17;
   localparam logic [4:0] ST_T_OUT = 5'd18;

   logic [4:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_P_RD;
            end
         end
         ST_P_RD: begin
            if (stat.is_tick) begin
               state_in = ST_T_RD;
            end else if (stat.s_at_end) begin
               state_in = ST_P_NEW;
            end else begin
               cmd.rd_s = 1'b1;
               state_in = ST_P_CMP;
            end
         end
         ST_P_CMP: begin
            if (stat.key_match) begin
               cmd.load_found = 1'b1;
               state_in       = ST_BASE;
            end else begin
               cmd.s_inc = 1'b1;
               state_in  = ST_P_RD;
            end
         end
         ST_P_NEW: begin
            if (stat.full) begin
               state_in = ST_DROP;
            end else begin
               cmd.rd_cnt = 1'b1;
               state_in   = ST_P_NLD;
            end
         end
         ST_P_NLD: begin
            cmd.load_new = 1'b1;
            state_in     = ST_BASE;
         end
         ST_DROP: begin
            if (stat.out_free) begin
               cmd.load_drop = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_BASE: begin
            cmd.calc_base = 1'b1;
            state_in      = ST_H_RD;
         end
         ST_H_RD: begin
            if (stat.h_at_end) begin
               state_in = ST_H_UPD;
            end else begin
               cmd.h_rd = 1'b1;
               state_in = ST_H_CMP;
            end
         end
         ST_H_CMP: begin
            if (stat.h_match) begin
               cmd.set_seen = 1'b1;
               state_in     = ST_H_UPD;
            end else begin
               cmd.h_inc = 1'b1;
               state_in  = ST_H_RD;
            end
         end
         ST_H_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_A_SET;
         end
         ST_A_SET: begin
            cmd.ack_set = 1'b1;
            state_in    = ST_A_RD;
         end
         ST_A_RD: begin
            cmd.a_rd = 1'b1;
            state_in = ST_A_LD;
         end
         ST_A_LD: begin
            if (stat.out_free) begin
               cmd.load_ack = 1'b1;
               state_in     = stat.rem_last ? ST_IDLE : ST_A_RD;
            end
         end
         ST_T_RD: begin
            if (stat.s_at_end) begin
               state_in = ST_T_OUT;
            end else begin
               cmd.rd_s = 1'b1;
               state_in = ST_T_CK;
            end
         end
         ST_T_CK: begin
            if (stat.idle_hit) begin
               cmd.evict = 1'b1;
               state_in  = stat.i_is_last ? ST_T_RD : ST_T_MRD;
            end else begin
               cmd.s_inc = 1'b1;
               state_in  = ST_T_RD;
            end
         end
         ST_T_MRD: begin
            cmd.rd_cnt = 1'b1;
            state_in   = ST_T_MV;
         end
         ST_T_MV: begin
            cmd.mv_write = 1'b1;
            state_in     = ST_T_MP;
         end
         ST_T_MP: begin
            cmd.mp_write = 1'b1;
            state_in     = ST_T_RD;
         end
         ST_T_OUT: begin
            if (stat.out_free) begin
               cmd.load_tick = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/psdf_dp.sv @@
// Datapath for the duplicate filter: sender table, history memory, counters,
// idle limit register and result register. Depends on psdf_pkg.
`timescale 1ns / 1ps

module psdf_dp import psdf_pkg::*; #(
   parameter int SENDERS   = 256,
   parameter int HISTORY   = 128,
   parameter int ACK_DEPTH = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [7:0]    csr_wr_data,
   input  logic          req_command,
   input  logic [31:0]   req_src_addr,
   input  logic [15:0]   req_src_port,
   input  logic [31:0]   req_msg_index,
   input  psdf_cmd_type  cmd,
   output psdf_stat_type stat,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic          rsp_is_new,
   output logic [31:0]   rsp_ack_index,
   output logic [8:0]    rsp_evicted,
   output logic          rsp_last
);

   localparam int SW  = (SENDERS > 1) ? $clog2(SENDERS) : 1;
   localparam int CW  = $clog2(SENDERS + 1);
   localparam int HW  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
   localparam int FW  = $clog2(HISTORY + 1);
   localparam int HAW = (SENDERS * HISTORY > 1) ? $clog2(SENDERS * HISTORY) : 1;
   localparam int RW  = $clog2(ACK_DEPTH + 1);
   localparam int MW  = (FW > RW) ? FW : RW;

   localparam logic [CW-1:0]  SENDERS_C = CW'(SENDERS);
   localparam logic [FW-1:0]  HIST_F    = FW'(HISTORY);
   localparam logic [HW-1:0]  HIST_LAST = HW'(HISTORY - 1);
   localparam logic [HAW-1:0] HIST_A    = HAW'(HISTORY);
   localparam logic [FW:0]    HIST_S    = (FW + 1)'(HISTORY);

   // sender table
   logic [31:0]   t_addr_mem [SENDERS];
   logic [15:0]   t_port_mem [SENDERS];
   logic [31:0]   t_last_mem [SENDERS];
   logic [FW-1:0] t_fill_mem [SENDERS];
   logic [HW-1:0] t_head_mem [SENDERS];
   logic [SW-1:0] t_ptr_mem  [SENDERS];
   // history rings, one bank of HISTORY per pointer
   logic [31:0]   h_mem [SENDERS * HISTORY];

   logic [31:0]   rd_addr_ff, rd_last_ff, h_rd_ff;
   logic [15:0]   rd_port_ff;
   logic [FW-1:0] rd_fill_ff;
   logic [HW-1:0] rd_head_ff;
   logic [SW-1:0] rd_ptr_ff;

   logic [7:0]    limit_ff, limit_in;
   logic [31:0]   now_ff, now_in;
   logic [CW-1:0] count_ff, count_in, hw_ff, hw_in, s_ff, s_in;
   logic          tick_ff, tick_in, new_ff, new_in, seen_ff, seen_in;
   logic [31:0]   key_addr_ff, key_addr_in, idx_ff, idx_in;
   logic [15:0]   key_port_ff, key_port_in;
   logic [31:0]   ent_addr_ff, ent_addr_in;
   logic [15:0]   ent_port_ff, ent_port_in;
   logic [FW-1:0] ent_fill_ff, ent_fill_in, j_ff, j_in;
   logic [HW-1:0] ent_head_ff, ent_head_in, pos_ff, pos_in;
   logic [SW-1:0] ent_ptr_ff, ent_ptr_in, evptr_ff, evptr_in;
   logic [HAW-1:0] base_ff, base_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [8:0]    ev_ff, ev_in;

   logic          out_valid_ff, out_valid_in, out_new_ff, out_new_in, out_last_ff, out_last_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic [31:0]   out_index_ff, out_index_in;
   logic [8:0]    out_ev_ff, out_ev_in;

   logic          t_rd_en, t_wr_en, h_rd_en, h_wr_en;
   logic [SW-1:0] t_rd_idx, t_wr_idx, w_ptr;
   logic [31:0]   w_addr, w_last;
   logic [15:0]   w_port;
   logic [FW-1:0] w_fill, upd_fill;
   logic [HW-1:0] w_head, upd_head, pos_inc, pos_dec;
   logic [HAW-1:0] h_idx;
   logic [FW:0]   start_sum;
   logic [FW:0]   start_pos;
   logic [MW-1:0] ack_n;

   assign pos_inc = (pos_ff == HIST_LAST) ? '0 : pos_ff + HW'(1);
   assign pos_dec = (pos_ff == '0) ? HIST_LAST : pos_ff - HW'(1);

   always_comb begin
      upd_fill = ent_fill_ff;
      upd_head = ent_head_ff;
      if (!seen_ff) begin
         if (ent_fill_ff < HIST_F) begin
            upd_fill = ent_fill_ff + FW'(1);
         end else begin
            upd_head = (ent_head_ff == HIST_LAST) ? '0 : ent_head_ff + HW'(1);
         end
      end
   end

   assign start_sum = (FW + 1)'(ent_head_ff) + (FW + 1)'(ent_fill_ff) - (FW + 1)'(1);
   assign start_pos = (start_sum >= HIST_S) ? start_sum - HIST_S : start_sum;
   assign ack_n     = (MW'(ent_fill_ff) < MW'(ACK_DEPTH)) ? MW'(ent_fill_ff) : MW'(ACK_DEPTH);

   // table ports
   assign t_rd_en  = cmd.rd_s | cmd.rd_cnt;
   assign t_rd_idx = cmd.rd_cnt ? count_ff[SW-1:0] : s_ff[SW-1:0];
   assign t_wr_en  = cmd.update | cmd.mv_write | cmd.mp_write;
   assign t_wr_idx = cmd.mp_write ? count_ff[SW-1:0] : s_ff[SW-1:0];

   always_comb begin
      if (cmd.update) begin
         w_addr = ent_addr_ff;
         w_port = ent_port_ff;
         w_last = now_ff;
         w_fill = upd_fill;
         w_head = upd_head;
         w_ptr  = ent_ptr_ff;
      end else begin
         w_addr = rd_addr_ff;
         w_port = rd_port_ff;
         w_last = rd_last_ff;
         w_fill = rd_fill_ff;
         w_head = rd_head_ff;
         w_ptr  = cmd.mp_write ? evptr_ff : rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (t_wr_en) begin
         t_addr_mem[t_wr_idx] <= w_addr;
         t_port_mem[t_wr_idx] <= w_port;
         t_last_mem[t_wr_idx] <= w_last;
         t_fill_mem[t_wr_idx] <= w_fill;
         t_head_mem[t_wr_idx] <= w_head;
         t_ptr_mem[t_wr_idx]  <= w_ptr;
      end
      if (t_rd_en) begin
         rd_addr_ff <= t_addr_mem[t_rd_idx];
         rd_port_ff <= t_port_mem[t_rd_idx];
         rd_last_ff <= t_last_mem[t_rd_idx];
         rd_fill_ff <= t_fill_mem[t_rd_idx];
         rd_head_ff <= t_head_mem[t_rd_idx];
         rd_ptr_ff  <= t_ptr_mem[t_rd_idx];
      end
   end

   // history ports
   assign h_idx   = base_ff + HAW'(pos_ff);
   assign h_rd_en = cmd.h_rd | cmd.a_rd;
   assign h_wr_en = cmd.update & ~seen_ff;

   always_ff @(posedge clock) begin
      if (h_wr_en) begin
         h_mem[h_idx] <= idx_ff;
      end
      if (h_rd_en) begin
         h_rd_ff <= h_mem[h_idx];
      end
   end

   // status to controller
   always_comb begin
      stat.is_tick   = (tick_ff == CMD_TICK);
      stat.s_at_end  = (s_ff == count_ff);
      stat.key_match = (rd_addr_ff == key_addr_ff) && (rd_port_ff == key_port_ff);
      stat.full      = (count_ff == SENDERS_C);
      stat.h_at_end  = (j_ff == ent_fill_ff);
      stat.h_match   = (h_rd_ff == idx_ff);
      stat.out_free  = ~out_valid_ff | rsp_ready;
      stat.idle_hit  = (now_ff - rd_last_ff) > {24'b0, limit_ff};
      stat.i_is_last = (s_ff == count_ff - CW'(1));
      stat.rem_last  = (rem_ff == RW'(1));
   end

   always_comb begin
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      now_in       = now_ff;
      count_in     = count_ff;
      hw_in        = hw_ff;
      s_in         = s_ff;
      tick_in      = tick_ff;
      new_in       = new_ff;
      seen_in      = seen_ff;
      key_addr_in  = key_addr_ff;
      key_port_in  = key_port_ff;
      idx_in       = idx_ff;
      ent_addr_in  = ent_addr_ff;
      ent_port_in  = ent_port_ff;
      ent_fill_in  = ent_fill_ff;
      ent_head_in  = ent_head_ff;
      ent_ptr_in   = ent_ptr_ff;
      evptr_in     = evptr_ff;
      base_in      = base_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      ev_in        = ev_ff;
      out_valid_in  = out_valid_ff & ~rsp_ready;
      out_status_in = out_status_ff;
      out_new_in    = out_new_ff;
      out_index_in  = out_index_ff;
      out_ev_in     = out_ev_ff;
      out_last_in   = out_last_ff;

      if (cmd.capture) begin
         tick_in     = req_command;
         key_addr_in = req_src_addr;
         key_port_in = req_src_port;
         idx_in      = req_msg_index;
         s_in        = '0;
         new_in      = 1'b0;
         seen_in     = 1'b0;
         ev_in       = '0;
         if (req_command == CMD_TICK) begin
            now_in = now_ff + 32'd1;
         end
      end
      if (cmd.s_inc) begin
         s_in = s_ff + CW'(1);
      end
      if (cmd.load_found) begin
         ent_addr_in = rd_addr_ff;
         ent_port_in = rd_port_ff;
         ent_fill_in = rd_fill_ff;
         ent_head_in = rd_head_ff;
         ent_ptr_in  = rd_ptr_ff;
      end
      if (cmd.load_new) begin
         ent_addr_in = key_addr_ff;
         ent_port_in = key_port_ff;
         ent_fill_in = '0;
         ent_head_in = '0;
         ent_ptr_in  = (count_ff < hw_ff) ? rd_ptr_ff : count_ff[SW-1:0];
         s_in        = count_ff;
         new_in      = 1'b1;
      end
      if (cmd.calc_base) begin
         base_in = HAW'(ent_ptr_ff) * HIST_A;
         j_in    = '0;
         pos_in  = ent_head_ff;
      end
      if (cmd.h_inc) begin
         j_in   = j_ff + FW'(1);
         pos_in = pos_inc;
      end
      if (cmd.set_seen) begin
         seen_in = 1'b1;
      end
      if (cmd.update) begin
         ent_fill_in = upd_fill;
         ent_head_in = upd_head;
         if (new_ff) begin
            count_in = count_ff + CW'(1);
            if (count_ff == hw_ff) begin
               hw_in = hw_ff + CW'(1);
            end
         end
      end
      if (cmd.ack_set) begin
         pos_in = HW'(start_pos);
         rem_in = RW'(ack_n);
      end
      if (cmd.load_ack) begin
         out_valid_in  = 1'b1;
         out_status_in = STATUS_ACK;
         out_new_in    = ~seen_ff;
         out_index_in  = h_rd_ff;
         out_ev_in     = '0;
         out_last_in   = (rem_ff == RW'(1));
         rem_in        = rem_ff - RW'(1);
         pos_in        = pos_dec;
      end
      if (cmd.load_drop) begin
         out_valid_in  = 1'b1;
         out_status_in = STATUS_DROP;
         out_new_in    = 1'b0;
         out_index_in  = '0;
         out_ev_in     = '0;
         out_last_in   = 1'b1;
      end
      if (cmd.evict) begin
         count_in = count_ff - CW'(1);
         evptr_in = rd_ptr_ff;
         if (ev_ff != 9'h1FF) begin
            ev_in = ev_ff + 9'd1;
         end
      end
      if (cmd.load_tick) begin
         out_valid_in  = 1'b1;
         out_status_in = STATUS_TICK;
         out_new_in    = 1'b0;
         out_index_in  = '0;
         out_ev_in     = ev_ff;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= IDLE_LIMIT_RESET;
         now_ff       <= '0;
         count_ff     <= '0;
         hw_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         now_ff       <= now_in;
         count_ff     <= count_in;
         hw_ff        <= hw_in;
         out_valid_ff <= out_valid_in;
      end
      s_ff          <= s_in;
      tick_ff       <= tick_in;
      new_ff        <= new_in;
      seen_ff       <= seen_in;
      key_addr_ff   <= key_addr_in;
      key_port_ff   <= key_port_in;
      idx_ff        <= idx_in;
      ent_addr_ff   <= ent_addr_in;
      ent_port_ff   <= ent_port_in;
      ent_fill_ff   <= ent_fill_in;
      ent_head_ff   <= ent_head_in;
      ent_ptr_ff    <= ent_ptr_in;
      evptr_ff      <= evptr_in;
      base_ff       <= base_in;
      j_ff          <= j_in;
      pos_ff        <= pos_in;
      rem_ff        <= rem_in;
      ev_ff         <= ev_in;
      out_status_ff <= out_status_in;
      out_new_ff    <= out_new_in;
      out_index_ff  <= out_index_in;
      out_ev_ff     <= out_ev_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_is_new    = out_new_ff;
   assign rsp_ack_index = out_index_ff;
   assign rsp_evicted   = out_ev_ff;
   assign rsp_last      = out_last_ff;

endmodule

@@ rtl/core/per_sender_duplicate_filter_ack.sv @@
// Top level of the per-sender duplicate filter. Depends on psdf_pkg,
// psdf_req_if, psdf_rsp_if, psdf_ctrl and psdf_dp.
`timescale 1ns / 1ps

// Takes one item at a time. A packet looks its sender up in the table entry by
// entry, scans that sender's history ring index by index, updates the entry,
// then gives min(fill, ACK_DEPTH) ack transfers, newest first. A tick checks
// every sender and evicts those idle for more than idle_limit ticks. The table
// and history memories are single-ported and their read data is registered.
// Evicted senders swap a bank pointer, so no history is copied. No clearing
// pass is needed after reset. idle_limit is written through csr_wr_en /
// csr_wr_data; the user must write it only while the block is idle, as the
// block itself has no check for this.

module per_sender_duplicate_filter_ack import psdf_pkg::*; #(
   parameter int SENDERS   = 256,
   parameter int HISTORY   = 128,
   parameter int ACK_DEPTH = 20
) (
   input  logic        clock,
   input  logic        reset,
   psdf_req_if.sink    req_if,
   psdf_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   psdf_cmd_type  cmd;
   psdf_stat_type stat;

   psdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   psdf_dp #(
      .SENDERS   (SENDERS),
      .HISTORY   (HISTORY),
      .ACK_DEPTH (ACK_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_command   (req_if.command),
      .req_src_addr  (req_if.src_addr),
      .req_src_port  (req_if.src_port),
      .req_msg_index (req_if.msg_index),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_status    (rsp_if.status),
      .rsp_is_new    (rsp_if.is_new),
      .rsp_ack_index (rsp_if.ack_index),
      .rsp_evicted   (rsp_if.evicted),
      .rsp_last      (rsp_if.last)
   );

endmodule
